/* rtl/pksw_pkg.sv */
// ----------------------------------------------------------------------------
// pksw_pkg
// Shared types and constants of the per-key sliding-window limiter: op and
// status codes, register indexes, controller states, command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pksw_pkg;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 32;
	localparam int LIMIT_W    = 5;
	localparam int WINDOW_W   = 32;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_HIT_LIMIT     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b1;

	localparam logic [LIMIT_W-1:0]  HIT_LIMIT_RST = 5'd0;
	localparam logic [WINDOW_W-1:0] WINDOW_RST    = 32'd60;

	typedef enum logic [OP_W-1:0] {
		OP_ALLOW = 2'd0,
		OP_PRUNE = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_OVER = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_NOTFOUND,
		S_FREE,
		S_ALLOC,
		S_META,
		S_DROP_RD,
		S_DROP_CHK,
		S_JUDGE,
		S_SW_NEXT,
		S_SW_POST,
		S_DONE
	} state_t;

	typedef struct packed {
		logic    load;
		logic    cnt_clr;
		logic    cnt_inc;
		logic    tag_rd;
		logic    slot_from_scan;
		logic    slot_from_cnt;
		logic    alloc;
		logic    meta_rd;
		logic    hit_rd;
		logic    drop_one;
		logic    meta_wr;
		logic    append;
		logic    free_slot;
		logic    clear_all;
		logic    res_ld;
		status_t res_status;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic limit_zero;
		logic match;
		logic scan_pend;
		logic cnt_end;
		logic cur_valid;
		logic full;
		logic fill_zero;
		logic expired;
		logic over_limit;
		logic out_free;
	} sts_t;

endpackage

/* rtl/pksw_dp.sv */
// ----------------------------------------------------------------------------
// pksw_dp
// Datapath: config registers, key tag / ring meta / hit log memories, valid
// bits, key count, scan counter, working ring pointers and result register.
// ----------------------------------------------------------------------------
module pksw_dp #(
	parameter int TABLE_KEYS   = 256,
	parameter int HITS_PER_KEY = 16,
	parameter int TIME_BITS    = 48,
	parameter int KEY_BITS     = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pksw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pksw_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [pksw_pkg::OP_W-1:0]       op,
	input  logic [KEY_BITS-1:0]             key_hash,
	input  logic [TIME_BITS-1:0]            now,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [pksw_pkg::STATUS_W-1:0]   status,
	output logic [$clog2(TABLE_KEYS+1)-1:0] keys_in_use,
	input  pksw_pkg::cmd_t                  cmd,
	output pksw_pkg::sts_t                  sts
);
	import pksw_pkg::*;

	localparam int IW = $clog2(TABLE_KEYS);
	localparam int CW = $clog2(TABLE_KEYS + 1);
	localparam int HW = (HITS_PER_KEY > 1) ? $clog2(HITS_PER_KEY) : 1;
	localparam int FW = $clog2(HITS_PER_KEY + 1);
	localparam int MW = HW + FW;
	localparam int AW = $clog2(TABLE_KEYS * HITS_PER_KEY);
	localparam int SW = ((TIME_BITS > WINDOW_W) ? TIME_BITS : WINDOW_W) + 1;
	localparam int LW = (FW > LIMIT_W) ? FW : LIMIT_W;

	logic [KEY_BITS-1:0]  tag_mem [TABLE_KEYS];
	logic [MW-1:0]        meta_mem [TABLE_KEYS];
	logic [TIME_BITS-1:0] hit_mem [TABLE_KEYS*HITS_PER_KEY];

	logic [LIMIT_W-1:0]    hit_limit_q;
	logic [WINDOW_W-1:0]   window_q;
	logic [OP_W-1:0]       op_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [CW-1:0]         cnt_q;
	logic [KEY_BITS-1:0]   tag_s1;
	logic [IW-1:0]         idx_s1;
	logic                  vld_s1;
	logic                  pend_s1;
	logic [IW-1:0]         slot_q;
	logic [HW-1:0]         head_q;
	logic [FW-1:0]         fill_q;
	logic [TIME_BITS-1:0]  hit_q;
	logic [TABLE_KEYS-1:0] valid_q;
	logic [CW-1:0]         key_count_q;
	logic                  out_valid_q;
	logic [STATUS_W-1:0]   status_q;
	logic [CW-1:0]         keys_q;

	logic [IW-1:0] cnt_idx;
	logic [HW-1:0] head_next;
	logic [FW:0]   pos_sum;
	logic [FW:0]   pos_wrap;
	logic [AW-1:0] hit_base;
	logic [AW-1:0] hit_rd_addr;
	logic [AW-1:0] hit_wr_addr;
	logic          meta_we;
	logic [MW-1:0] meta_wdata;

	assign cnt_idx   = cnt_q[IW-1:0];
	assign head_next = (head_q == HW'(HITS_PER_KEY - 1)) ? '0 : head_q + 1'b1;
	// ring slot of the next append: (head + fill) mod depth, sum stays below 2x depth
	assign pos_sum   = (FW+1)'(head_q) + (FW+1)'(fill_q);
	assign pos_wrap  = (pos_sum >= (FW+1)'(HITS_PER_KEY)) ?
		pos_sum - (FW+1)'(HITS_PER_KEY) : pos_sum;
	assign hit_base    = AW'(slot_q) * AW'(HITS_PER_KEY);
	assign hit_rd_addr = hit_base + AW'(head_q);
	assign hit_wr_addr = hit_base + AW'(pos_wrap[HW-1:0]);

	assign meta_we = cmd.alloc | cmd.meta_wr | cmd.append;
	always_comb begin
		if (cmd.alloc) begin
			meta_wdata = '0;
		end else if (cmd.append) begin
			meta_wdata = {head_q, fill_q + 1'b1};
		end else begin
			meta_wdata = {head_q, fill_q};
		end
	end

	// status toward the controller
	assign sts.op         = op_t'(op_q);
	assign sts.limit_zero = (hit_limit_q == '0);
	assign sts.match      = pend_s1 && vld_s1 && (tag_s1 == key_q);
	assign sts.scan_pend  = pend_s1;
	assign sts.cnt_end    = (cnt_q == CW'(TABLE_KEYS));
	assign sts.cur_valid  = valid_q[cnt_idx];
	assign sts.full       = (key_count_q == CW'(TABLE_KEYS));
	assign sts.fill_zero  = (fill_q == '0);
	assign sts.expired    = (SW'(hit_q) + SW'(window_q)) <= SW'(now_q);
	assign sts.over_limit = (LW'(fill_q) >= LW'(hit_limit_q)) ||
		(fill_q == FW'(HITS_PER_KEY));
	assign sts.out_free   = !out_valid_q || out_ready;

	// memories
	always_ff @(posedge clk) begin
		if (cmd.alloc) begin
			tag_mem[slot_q] <= key_q;
		end
		if (cmd.tag_rd) begin
			tag_s1 <= tag_mem[cnt_idx];
			idx_s1 <= cnt_idx;
			vld_s1 <= valid_q[cnt_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (meta_we) begin
			meta_mem[slot_q] <= meta_wdata;
		end
		if (cmd.meta_rd) begin
			{head_q, fill_q} <= meta_mem[slot_q];
		end else if (cmd.alloc) begin
			head_q <= '0;
			fill_q <= '0;
		end else if (cmd.drop_one) begin
			head_q <= head_next;
			fill_q <= fill_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.append) begin
			hit_mem[hit_wr_addr] <= now_q;
		end
		if (cmd.hit_rd) begin
			hit_q <= hit_mem[hit_rd_addr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op;
			key_q <= key_hash;
			now_q <= now;
		end
		if (cmd.slot_from_scan) begin
			slot_q <= idx_s1;
		end else if (cmd.slot_from_cnt) begin
			slot_q <= cnt_idx;
		end
		if (cmd.res_ld) begin
			status_q <= cmd.res_status;
			keys_q   <= key_count_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_limit_q <= HIT_LIMIT_RST;
			window_q    <= WINDOW_RST;
			cnt_q       <= '0;
			pend_s1     <= 1'b0;
			valid_q     <= '0;
			key_count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HIT_LIMIT:     hit_limit_q <= cfg_data[LIMIT_W-1:0];
					CFG_WINDOW_LENGTH: window_q    <= cfg_data[WINDOW_W-1:0];
					default: ;
				endcase
			end
			if (cmd.cnt_clr) begin
				cnt_q <= '0;
			end else if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + 1'b1;
			end
			pend_s1 <= cmd.tag_rd;
			if (cmd.clear_all) begin
				valid_q     <= '0;
				key_count_q <= '0;
			end else if (cmd.alloc) begin
				valid_q[slot_q] <= 1'b1;
				key_count_q     <= key_count_q + 1'b1;
			end else if (cmd.free_slot) begin
				valid_q[slot_q] <= 1'b0;
				if (key_count_q != '0) begin
					key_count_q <= key_count_q - 1'b1;
				end
			end
			if (cmd.res_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign keys_in_use = keys_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		key_count_q <= CW'(TABLE_KEYS))
		else $error("key count above table size");
	a_count_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(key_count_q))
		else $error("key count disagrees with valid bits");
	a_alloc_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.alloc |-> !valid_q[slot_q])
		else $error("allocation into a slot in use");
	a_res_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_ld |-> (!out_valid_q || out_ready))
		else $error("result register overwritten before taken");
`endif

endmodule

/* rtl/pksw_ctrl.sv */
// ----------------------------------------------------------------------------
// pksw_ctrl
// Controller: sequences key scan, free-slot search, ring drop, table sweep
// and result hand-off through commands to the datapath.
// ----------------------------------------------------------------------------
module pksw_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  pksw_pkg::sts_t sts,
	output pksw_pkg::cmd_t cmd
);
	import pksw_pkg::*;

	state_t  state_q, state_d;
	logic    sweep_q, sweep_d;
	logic    alloc_q, alloc_d;
	status_t code_q, code_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sweep_q <= 1'b0;
			alloc_q <= 1'b0;
			code_q  <= ST_OK;
		end else begin
			state_q <= state_d;
			sweep_q <= sweep_d;
			alloc_q <= alloc_d;
			code_q  <= code_d;
		end
	end

	always_comb begin
		state_d        = state_q;
		sweep_d        = sweep_q;
		alloc_d        = alloc_q;
		code_d         = code_q;
		cmd            = '0;
		cmd.res_status = code_q;
		in_ready       = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				code_d  = ST_OK;
				sweep_d = 1'b0;
				alloc_d = 1'b0;
				unique case (sts.op)
					OP_ALLOW: begin
						if (sts.limit_zero) begin
							state_d = S_DONE;
						end else begin
							cmd.cnt_clr = 1'b1;
							state_d     = S_SCAN;
						end
					end
					OP_PRUNE: begin
						cmd.cnt_clr = 1'b1;
						sweep_d     = 1'b1;
						state_d     = S_SW_NEXT;
					end
					OP_CLEAR: begin
						cmd.clear_all = 1'b1;
						state_d       = S_DONE;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (sts.match) begin
					cmd.slot_from_scan = 1'b1;
					state_d            = S_META;
				end else if (sts.cnt_end && !sts.scan_pend) begin
					state_d = S_NOTFOUND;
				end else if (!sts.cnt_end) begin
					cmd.tag_rd  = 1'b1;
					cmd.cnt_inc = 1'b1;
				end
			end
			S_NOTFOUND: begin
				cmd.cnt_clr = 1'b1;
				if (sts.full) begin
					sweep_d = 1'b1;
					alloc_d = 1'b1;
					state_d = S_SW_NEXT;
				end else begin
					state_d = S_FREE;
				end
			end
			S_FREE: begin
				if (sts.cnt_end) begin
					code_d  = ST_FULL;
					state_d = S_DONE;
				end else if (!sts.cur_valid) begin
					cmd.slot_from_cnt = 1'b1;
					state_d           = S_ALLOC;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_ALLOC: begin
				cmd.alloc = 1'b1;
				state_d   = S_JUDGE;
			end
			S_META: begin
				cmd.meta_rd = 1'b1;
				state_d     = S_DROP_RD;
			end
			S_DROP_RD: begin
				if (sts.fill_zero) begin
					state_d = sweep_q ? S_SW_POST : S_JUDGE;
				end else begin
					cmd.hit_rd = 1'b1;
					state_d    = S_DROP_CHK;
				end
			end
			S_DROP_CHK: begin
				if (sts.expired) begin
					cmd.drop_one = 1'b1;
					state_d      = S_DROP_RD;
				end else begin
					state_d = sweep_q ? S_SW_POST : S_JUDGE;
				end
			end
			S_JUDGE: begin
				if (sts.over_limit) begin
					cmd.meta_wr = 1'b1;
					code_d      = ST_OVER;
				end else begin
					cmd.append = 1'b1;
					code_d     = ST_OK;
				end
				state_d = S_DONE;
			end
			S_SW_NEXT: begin
				if (sts.cnt_end) begin
					sweep_d = 1'b0;
					if (!alloc_q) begin
						state_d = S_DONE;
					end else if (sts.full) begin
						code_d  = ST_FULL;
						state_d = S_DONE;
					end else begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_FREE;
					end
				end else if (sts.cur_valid) begin
					cmd.slot_from_cnt = 1'b1;
					state_d           = S_META;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			S_SW_POST: begin
				cmd.meta_wr   = 1'b1;
				cmd.free_slot = sts.fill_zero;
				cmd.cnt_inc   = 1'b1;
				state_d       = S_SW_NEXT;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.res_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

/* rtl/per_key_sliding_window_limiter_core.sv */
// From the accepting cycle to the result register: clear, the unused op and limit-zero allows
// go straight from dispatch to the result; a prune's time grows with TABLE_KEYS, the keys in
// use and the dropped hits. A known-key allow's time grows with TABLE_KEYS and the dropped
// hits; a new key adds the free-slot search, and in a full table the sweep comes first.
// Items are processed one at a time; a new request is taken only after the last result is loaded.
// Reset clears control, valid bits and key count at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// per_key_sliding_window_limiter_core
// Per-key sliding-window-log rate limiter: allow, prune and clear ops over a
// table of keys, each with a ring of admitted timestamps.
// ----------------------------------------------------------------------------
module per_key_sliding_window_limiter_core #(
	parameter int TABLE_KEYS   = 256,
	parameter int HITS_PER_KEY = 16,
	parameter int TIME_BITS    = 48,
	parameter int KEY_BITS     = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration writes, to be made only while idle; the block does not enforce this
	input  logic                            cfg_we,
	input  logic [pksw_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pksw_pkg::CFG_DATA_W-1:0] cfg_data,
	// request item
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [pksw_pkg::OP_W-1:0]       op,
	input  logic [KEY_BITS-1:0]             key_hash,
	input  logic [TIME_BITS-1:0]            now,
	// result item
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [pksw_pkg::STATUS_W-1:0]   status,
	output logic [$clog2(TABLE_KEYS+1)-1:0] keys_in_use
);
	import pksw_pkg::*;

	// command and status bundles between the sequencer and the datapath
	cmd_t cmd;
	sts_t sts;

	// The controller walks each item through its phases:
	//   scan   - stream the tag memory, compare against the latched key
	//   sweep  - for a new key in a full table, or a prune op, visit each
	//            valid slot, drop expired hits, free emptied slots
	//   free   - find the first invalid slot and allocate it
	//   drop   - advance the ring head past hits that left the window
	//   judge  - refuse at the limit or with a full ring, else append now
	// The result register decouples the output side: the next item is
	// taken while a finished result still waits.
	pksw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath holds all storage; tag and hit memories need no reset since
	// only entries behind a set valid bit, or logged hits, are ever used.
	pksw_dp #(
		.TABLE_KEYS   (TABLE_KEYS),
		.HITS_PER_KEY (HITS_PER_KEY),
		.TIME_BITS    (TIME_BITS),
		.KEY_BITS     (KEY_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.key_hash    (key_hash),
		.now         (now),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.status      (status),
		.keys_in_use (keys_in_use),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule
